// ----- sv/xfp_pkg.sv -----
// ----------------------------------------------------------------------------
// xfp_pkg
// Shared constants, result codes and controller/datapath link types for the
// XOR partner frame pairing block.
// ----------------------------------------------------------------------------
package xfp_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int FRAME_BITS    = 36;
  localparam int FIELD_W       = 36;
  localparam int AGE_W         = 16;
  localparam int PB_W          = 5;
  localparam int TB_W          = 6;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 6;
  localparam int STAT_W        = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PG_SHIFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_BIT = 1'b1;

  localparam logic [PB_W-1:0] PG_SHIFT_RST = 5'd12;
  localparam logic [TB_W-1:0] PAIR_BIT_RST = 6'd13;

  localparam logic [STAT_W-1:0] STAT_STORED      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_PAIRED      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_PRESENT = 3'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_CONFIG  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL        = 3'd4;
  localparam logic [STAT_W-1:0] STAT_CLEARED     = 3'd5;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic quick;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/xfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// xfp_ctrl
// Sequencer: accept a word, run the table scan, commit the outcome.
// ----------------------------------------------------------------------------
module xfp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  xfp_pkg::sts_t sts,
  output xfp_pkg::cmd_t cmd
);
  import xfp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.commit = (state == S_FIN) && sts.out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.quick || sts.scan_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ----- sv/xfp_dp.sv -----
// ----------------------------------------------------------------------------
// xfp_dp
// Datapath: configuration, page table memories, scan compare and result word.
// ----------------------------------------------------------------------------
module xfp_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [xfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xfp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            req_type,
  input  logic [xfp_pkg::FIELD_W-1:0]     virt_page,
  input  logic                            present,
  input  logic [xfp_pkg::FIELD_W-1:0]     frame_number,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [xfp_pkg::STAT_W-1:0]      status,
  output logic [xfp_pkg::FIELD_W-1:0]     first_virt_page,
  output logic [xfp_pkg::FIELD_W-1:0]     first_frame,
  output logic [xfp_pkg::FIELD_W-1:0]     second_virt_page,
  output logic [xfp_pkg::FIELD_W-1:0]     second_frame,
  input  xfp_pkg::cmd_t                   cmd,
  output xfp_pkg::sts_t                   sts
);
  import xfp_pkg::*;

  logic [PB_W-1:0]          pg_shift;
  logic [TB_W-1:0]          pair_bit;
  logic                     cur_req;
  logic                     cur_present;
  logic [FIELD_W-1:0]       cur_virt;
  logic [FRAME_BITS-1:0]    cur_frame;
  logic [TABLE_ENTRIES-1:0] valid_bits;
  logic [AGE_W-1:0]         insert_count;

  logic [FRAME_BITS-1:0]    frame_mem [TABLE_ENTRIES];
  logic [FIELD_W-1:0]       virt_mem  [TABLE_ENTRIES];
  logic [AGE_W-1:0]         age_mem   [TABLE_ENTRIES];
  logic [FRAME_BITS-1:0]    rd_frame;
  logic [FIELD_W-1:0]       rd_virt;
  logic [AGE_W-1:0]         rd_age;

  logic [CNT_W-1:0]         cnt;
  logic                     cmp_vld;
  logic [IDX_W-1:0]         cmp_idx;
  logic                     best_found;
  logic [IDX_W-1:0]         best_idx;
  logic [AGE_W-1:0]         best_gap;
  logic [FIELD_W-1:0]       best_virt;
  logic [FRAME_BITS-1:0]    best_frame;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;

  logic                     bad_cfg;
  logic [TB_W-1:0]          diff;
  logic                     reachable;
  logic [FRAME_BITS-1:0]    want;
  logic                     issue;
  logic                     match;
  logic [AGE_W-1:0]         age_gap;
  logic                     store_en;

  assign bad_cfg   = pair_bit < {1'b0, pg_shift};
  assign diff      = pair_bit - {1'b0, pg_shift};
  assign reachable = diff < TB_W'(FRAME_BITS);
  assign want      = reachable ? (FRAME_BITS'(1) << diff) : '0;
  assign issue     = cmd.scan && !cnt[IDX_W];
  assign age_gap   = insert_count - rd_age;
  assign match     = cmp_vld && valid_bits[cmp_idx] && reachable
                     && ((rd_frame ^ cur_frame) == want);
  assign store_en  = cmd.commit && !cur_req && !bad_cfg && cur_present
                     && !best_found && free_found;

  assign sts.quick     = cur_req || bad_cfg || !cur_present;
  assign sts.scan_done = cnt[IDX_W] && !cmp_vld;
  assign sts.out_free  = !out_valid || out_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pg_shift <= PG_SHIFT_RST;
      pair_bit <= PAIR_BIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PG_SHIFT: pg_shift <= cfg_data[PB_W-1:0];
        CFG_PAIR_BIT: pair_bit <= cfg_data[TB_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_req     <= req_type;
      cur_present <= present;
      cur_virt    <= virt_page;
      cur_frame   <= frame_number[FRAME_BITS-1:0];
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_mem[free_idx] <= cur_frame;
      virt_mem[free_idx]  <= cur_virt;
      age_mem[free_idx]   <= insert_count;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_frame <= frame_mem[cnt[IDX_W-1:0]];
      rd_virt  <= virt_mem[cnt[IDX_W-1:0]];
      rd_age   <= age_mem[cnt[IDX_W-1:0]];
    end
  end

  // scan: advance address, compare returning entry
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      cmp_vld    <= 1'b0;
      best_found <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      cnt        <= '0;
      cmp_vld    <= 1'b0;
      best_found <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld <= issue;
      if (issue) cnt <= cnt + 1'b1;
      if (match && (!best_found || age_gap < best_gap)) begin
        best_found <= 1'b1;
      end
      if (cmp_vld && !valid_bits[cmp_idx] && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) cmp_idx <= cnt[IDX_W-1:0];
    if (cmd.scan && match && (!best_found || age_gap < best_gap)) begin
      best_idx   <= cmp_idx;
      best_gap   <= age_gap;
      best_virt  <= rd_virt;
      best_frame <= rd_frame;
    end
    if (cmd.scan && cmp_vld && !valid_bits[cmp_idx] && !free_found) begin
      free_idx <= cmp_idx;
    end
  end

  // commit: table update and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits   <= '0;
      insert_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (cur_req) begin
          valid_bits   <= '0;
          insert_count <= '0;
        end else if (!bad_cfg && cur_present) begin
          if (best_found) valid_bits[best_idx] <= 1'b0;
          else if (free_found) begin
            valid_bits[free_idx] <= 1'b1;
            insert_count         <= insert_count + 1'b1;
          end
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      first_virt_page  <= '0;
      first_frame      <= '0;
      second_virt_page <= '0;
      second_frame     <= '0;
      if (cur_req) status <= STAT_CLEARED;
      else if (bad_cfg) status <= STAT_BAD_CONFIG;
      else if (!cur_present) status <= STAT_NOT_PRESENT;
      else if (best_found) begin
        status           <= STAT_PAIRED;
        first_virt_page  <= best_virt;
        first_frame      <= FIELD_W'(best_frame);
        second_virt_page <= cur_virt;
        second_frame     <= FIELD_W'(cur_frame);
      end else if (free_found) status <= STAT_STORED;
      else status <= STAT_FULL;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while result word still held");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_ENTRIES))
    else $error("scan address beyond table");

  a_unpaired_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STAT_PAIRED) |-> (first_virt_page == '0 && second_frame == '0))
    else $error("pair fields set on unpaired result");

endmodule

// ----- sv/xor_partner_frame_pairing.sv -----
// ----------------------------------------------------------------------------
// xor_partner_frame_pairing
// Pairs resident pages whose physical addresses differ in one target bit.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per page item or clear request.
// Output channel (out_valid/out_ready): exactly one result word per input.
// Configuration channel (cfg_valid/cfg_ready): index 0 page size shift,
// index 1 partner bit; always ready, write only while the block is idle.
// A page item with good configuration that is present is searched: the
// table memory has a single read port and is scanned one entry a cycle.
// Clear requests, bad configuration and absent pages do not wait for the scan.
// One item is in work at a time; the next is accepted once the result is
// in the output register, so a waiting result does not block acceptance.
// Reset empties the table, zeroes the store counter and loads a page size
// shift of 12 and partner bit 13; no clearing pass is needed.
// A stalled receiver holds the result word; the block then finishes the
// current item and waits to commit it until the output register frees.
// ----------------------------------------------------------------------------
module xor_partner_frame_pairing (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xfp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [xfp_pkg::FIELD_W-1:0]     virt_page,
  input  logic                            present,
  input  logic [xfp_pkg::FIELD_W-1:0]     frame_number,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [xfp_pkg::STAT_W-1:0]      status,
  output logic [xfp_pkg::FIELD_W-1:0]     first_virt_page,
  output logic [xfp_pkg::FIELD_W-1:0]     first_frame,
  output logic [xfp_pkg::FIELD_W-1:0]     second_virt_page,
  output logic [xfp_pkg::FIELD_W-1:0]     second_frame
);
  import xfp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  xfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xfp_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req_type         (req_type),
    .virt_page        (virt_page),
    .present          (present),
    .frame_number     (frame_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .first_virt_page  (first_virt_page),
    .first_frame      (first_frame),
    .second_virt_page (second_virt_page),
    .second_frame     (second_frame),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
